/* rtl/core/itp_pkg.sv */
// shared types, character codes and helper functions for the infix to postfix converter
package itp_pkg;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   // shift control handed to every stack cell
   typedef struct packed {
      logic push;
      logic pop;
   } shift_ctl_type;

   // operator precedence, zero for anything that is not an operator
   function automatic logic [1:0] prec_of(input logic [7:0] ch);
      logic [1:0] p;
      p = 2'd0;
      if (ch == CH_STAR || ch == CH_SLASH || ch == CH_PERCENT) p = 2'd2;
      else if (ch == CH_PLUS || ch == CH_MINUS) p = 2'd1;
      return p;
   endfunction

   function automatic logic is_alnum(input logic [7:0] ch);
      return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
             (ch >= 8'h61 && ch <= 8'h7A);
   endfunction

endpackage

/* rtl/core/itp_cell.sv */
// one entry of the shifting operator stack
module itp_cell (
   input  logic                  clock,
   input  itp_pkg::shift_ctl_type ctl,
   input  logic [7:0]            from_above,
   input  logic [7:0]            from_below,
   output logic [7:0]            value
);
   import itp_pkg::*;

   logic [7:0] value_ff;
   logic [7:0] value_in;

   // push moves entries away from the top, pop moves them toward it
   always_comb begin
      value_in = value_ff;
      if (ctl.push) value_in = from_above;
      else if (ctl.pop) value_in = from_below;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* rtl/core/infix_to_postfix_converter_top.sv */
// top level of the shunting-yard infix to postfix converter
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  req     | in  | req_tvalid/req_tready  | tdata: symbol; tuser: command
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: out_symbol; tlast: last_of_run;
//          |     |                        | tuser: symbol_valid, expr_done, status
//
//  a word is taken only in the idle state and is then handled in the work state
//  a pass-through, push, ignored character or bare open paren drop returns to idle
//  each popped operator takes a work step of its own (cells shift one entry per cycle
//  when not stalled), then the push or drop; a nonempty flush ends on its last pop
//  a full rsp register with rsp_tready low stalls the work step
//  reset clears the state and the fill count; the stack cells are not cleared
module infix_to_postfix_converter_top #(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic       req_tuser,   // [0] command: end of expression
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_symbol
   output logic       rsp_tlast,   // last_of_run
   output logic [3:0] rsp_tuser    // [0] symbol_valid, [1] expr_done, [3:2] status
);
   import itp_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WORK = 1'b1;

   logic             state_ff,  state_in;
   logic             cmd_ff,    cmd_in;
   logic [7:0]       sym_ff,    sym_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_sym_ff,   rsp_sym_in;
   logic             rsp_sv_ff,    rsp_sv_in;
   logic             rsp_last_ff,  rsp_last_in;
   logic             rsp_done_ff,  rsp_done_in;
   logic [1:0]       rsp_stat_ff,  rsp_stat_in;

   shift_ctl_type    ctl;
   logic [7:0]       stk_val [STACK_DEPTH];

   // chain of stack cells, cell 0 holds the top of stack
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [7:0] above;
      logic [7:0] below;
      if (i == 0) begin : g_top
         assign above = sym_ff;
      end else begin : g_mid
         assign above = stk_val[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bot
         assign below = stk_val[i];
      end else begin : g_up
         assign below = stk_val[i+1];
      end
      itp_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .from_above (above),
         .from_below (below),
         .value      (stk_val[i])
      );
   end

   logic       out_free;
   logic       emit;
   logic       stack_empty, is_one, is_full;
   logic [7:0] top_sym, second_sym;
   logic [1:0] sym_prec;
   logic [7:0] e_sym;
   logic       e_sv, e_last, e_done;
   logic [1:0] e_stat;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign stack_empty = (count_ff == '0);
   assign is_one      = (count_ff == CNT_W'(1));
   assign is_full     = (count_ff == CNT_W'(STACK_DEPTH));
   assign top_sym     = stk_val[0];
   assign second_sym  = stk_val[1];
   assign sym_prec    = prec_of(sym_ff);
   assign req_tready  = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      sym_in   = sym_ff;
      count_in = count_ff;
      ctl      = '0;
      emit     = 1'b0;
      e_sym    = 8'h00;
      e_sv     = 1'b0;
      e_last   = 1'b0;
      e_done   = 1'b0;
      e_stat   = STATUS_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               sym_in   = req_tdata;
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (out_free) begin
               priority if (cmd_ff) begin
                  // flush: one pop per cycle unless stalled, done marks the bottom entry
                  if (stack_empty) begin
                     emit     = 1'b1;
                     e_last   = 1'b1;
                     e_done   = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     ctl.pop  = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                     emit     = 1'b1;
                     e_sym    = top_sym;
                     e_sv     = 1'b1;
                     e_last   = is_one;
                     e_done   = is_one;
                     if (is_one) state_in = ST_IDLE;
                  end
               end else if (is_alnum(sym_ff)) begin
                  emit     = 1'b1;
                  e_sym    = sym_ff;
                  e_sv     = 1'b1;
                  e_last   = 1'b1;
                  state_in = ST_IDLE;
               end else if (sym_ff == CH_LPAREN) begin
                  if (is_full) begin
                     emit     = 1'b1;
                     e_last   = 1'b1;
                     e_stat   = STATUS_OVERFLOW;
                     count_in = '0;
                  end else begin
                     ctl.push = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = ST_IDLE;
               end else if (sym_ff == CH_RPAREN) begin
                  if (stack_empty) begin
                     emit     = 1'b1;
                     e_last   = 1'b1;
                     e_stat   = STATUS_UNDERFLOW;
                     count_in = '0;
                     state_in = ST_IDLE;
                  end else if (top_sym == CH_LPAREN) begin
                     // matching open paren is dropped silently
                     ctl.pop  = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                     state_in = ST_IDLE;
                  end else begin
                     // look one entry ahead to tag the end of the run
                     ctl.pop  = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                     emit     = 1'b1;
                     e_sym    = top_sym;
                     e_sv     = 1'b1;
                     e_last   = !is_one && (second_sym == CH_LPAREN);
                  end
               end else if (sym_prec != 2'd0) begin
                  if (!stack_empty && (prec_of(top_sym) >= sym_prec)) begin
                     // after a pop the push cannot overflow
                     ctl.pop  = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                     emit     = 1'b1;
                     e_sym    = top_sym;
                     e_sv     = 1'b1;
                     e_last   = is_one || (prec_of(second_sym) < sym_prec);
                  end else if (is_full) begin
                     emit     = 1'b1;
                     e_last   = 1'b1;
                     e_stat   = STATUS_OVERFLOW;
                     count_in = '0;
                     state_in = ST_IDLE;
                  end else begin
                     ctl.push = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     state_in = ST_IDLE;
                  end
               end else begin
                  // any other byte is ignored
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result register: loads on emit, drains when the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_sv_in    = rsp_sv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_sym_in   = e_sym;
         rsp_sv_in    = e_sv;
         rsp_last_in  = e_last;
         rsp_done_in  = e_done;
         rsp_stat_in  = e_stat;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      sym_ff      <= sym_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_sv_ff   <= rsp_sv_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sym_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_stat_ff, rsp_done_ff, rsp_sv_ff};

endmodule

/* rtl/core/itp_checker.sv */
// port-level checks for the infix to postfix converter, bound to the top level
module itp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [3:0] rsp_tuser
);
   import itp_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // no character means a zero byte
   a_sym_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'h00)
      else $error("rsp data nonzero without symbol_valid");

   // end of expression always closes the run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("expr_done without last_of_run");

   // errors end the run and carry no character
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[3:2] != STATUS_OK) |->
         rsp_tlast && !rsp_tuser[0] && !rsp_tuser[1])
      else $error("malformed error word");

   // one word at a time: intake closes after an accept
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while busy");

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
